@@ design/assert_macros.svh @@
// Assertion macros used by the shortest-path core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DGSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DGSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/dgsp_pkg.sv @@
// Shared constants and types of the shortest-path core.
`default_nettype none
package dgsp_pkg;

  localparam int MaxVertices = 64;
  localparam int VtxW        = 6;
  localparam int CountW      = 7;
  localparam int EdgeAddrW   = 12;
  localparam int EdgeDepth   = 4096;
  localparam int WeightBits  = 16;
  localparam int EdgeW       = 17;
  localparam int DistW       = 22;
  localparam logic [DistW-1:0] DistMax = 22'h3F_FFFF;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdRun   = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [VtxW-1:0]       from_vertex;
    logic [VtxW-1:0]       to_vertex;
    logic                  edge_present;
    logic [WeightBits-1:0] edge_weight;
    logic [VtxW-1:0]       source_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VtxW-1:0]  vertex_index;
    logic             reachable;
    logic [DistW-1:0] path_length;
    logic             last_result;
  } out_item_t;

  typedef struct packed {
    logic             clear;
    logic             sample;
    logic             cand;
    logic [VtxW-1:0]  idx;
    logic [DistW-1:0] cost;
  } scan_req_t;

  typedef struct packed {
    logic             found;
    logic [VtxW-1:0]  idx;
    logic [DistW-1:0] cost;
  } scan_res_t;

endpackage
`default_nettype wire

@@ design/dgsp_in_if.sv @@
// Input channel: command transactions into the core.
`default_nettype none
interface dgsp_in_if;
  import dgsp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/dgsp_out_if.sv @@
// Output channel: per-vertex result transactions from the core.
`default_nettype none
interface dgsp_out_if;
  import dgsp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/dense_graph_shortest_path_core.sv @@
// Operation: a write transaction updates one edge entry; a run does a scan pass and a relax pass
// for each of the k reachable vertices, then a final scan pass, then one result per vertex in use.
// Throughput: one run at a time; each scan pass walks the distance memory and each relax pass
// walks it and one edge-memory row, at one entry per cycle; each result is read, loaded, then held.
// Reset: a clearing pass writes no-edge to every edge entry; no input
// transaction is taken until it ends. vertex_count resets to 64.
`default_nettype none
`include "assert_macros.svh"
module dense_graph_shortest_path_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [dgsp_pkg::CountW-1:0] cfg_data_i,
  dgsp_in_if.sink                       in_ch,
  dgsp_out_if.source                    out_ch
);
  import dgsp_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } state_e;

  state_e                 state_q, state_d;
  logic [EdgeAddrW-1:0]   clr_addr_q, clr_addr_d;
  logic [CountW-1:0]      vcount_q, vcount_d;
  logic [CountW-1:0]      n_q, n_d;
  logic [CountW-1:0]      cnt_q, cnt_d;
  logic                   pv_q, pv_d;
  logic [VtxW-1:0]        pidx_q, pidx_d;
  logic [MaxVertices-1:0] visited_q, visited_d;
  logic [MaxVertices-1:0] tvalid_q, tvalid_d;
  logic [VtxW-1:0]        sel_q, sel_d;
  logic [DistW-1:0]       seld_q, seld_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic [CountW-1:0]    n_active;
  logic                 edge_we;
  logic [EdgeAddrW-1:0] edge_waddr;
  logic [EdgeW-1:0]     edge_wdata;
  logic [EdgeAddrW-1:0] edge_raddr;
  logic [EdgeW-1:0]     edge_rdata;
  logic                 dist_we;
  logic [VtxW-1:0]      dist_waddr;
  logic [DistW-1:0]     dist_wdata;
  logic [DistW-1:0]     dist_rdata;
  logic [DistW:0]       relax_sum;
  logic [DistW-1:0]     relax_nd;
  scan_req_t            scan_req;
  scan_res_t            scan_res;
  logic                 in_accept;

  dgsp_ram #(.Depth(EdgeDepth), .Width(EdgeW)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  dgsp_ram #(.Depth(MaxVertices), .Width(DistW)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (cnt_q[VtxW-1:0]),
    .rdata_o (dist_rdata)
  );

  dgsp_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scan_req),
    .res_o  (scan_res)
  );

  always_comb begin
    if (vcount_q == '0) begin
      n_active = CountW'(1);
    end else if (vcount_q > CountW'(MaxVertices)) begin
      n_active = CountW'(MaxVertices);
    end else begin
      n_active = vcount_q;
    end
  end

  assign in_accept  = in_ch.valid && in_ch.ready;
  assign edge_raddr = {sel_q, cnt_q[VtxW-1:0]};
  assign relax_sum  = {1'b0, seld_q} + (DistW+1)'(edge_rdata[WeightBits-1:0]);
  assign relax_nd   = relax_sum[DistW] ? DistMax : relax_sum[DistW-1:0];

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    vcount_d    = vcount_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    visited_d   = visited_q;
    tvalid_d    = tvalid_q;
    sel_d       = sel_q;
    seld_d      = seld_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    edge_we     = 1'b0;
    edge_waddr  = clr_addr_q;
    edge_wdata  = '0;
    dist_we     = 1'b0;
    dist_waddr  = pidx_q;
    dist_wdata  = relax_nd;
    scan_req    = '0;
    scan_req.idx  = pidx_q;
    scan_req.cost = dist_rdata;

    if (cfg_we_i) begin
      vcount_d = cfg_data_i;
    end

    case (state_q)
      ST_CLEAR: begin
        edge_we    = 1'b1;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == EdgeAddrW'(EdgeDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (in_ch.payload.cmd == CmdWrite) begin
            edge_we    = 1'b1;
            edge_waddr = {in_ch.payload.from_vertex, in_ch.payload.to_vertex};
            edge_wdata = {in_ch.payload.edge_present,
                          in_ch.payload.edge_present ? in_ch.payload.edge_weight
                                                     : WeightBits'(0)};
          end else begin
            n_d        = n_active;
            cnt_d      = '0;
            visited_d  = '0;
            tvalid_d   = '0;
            if ({1'b0, in_ch.payload.source_vertex} < n_active) begin
              tvalid_d[in_ch.payload.source_vertex] = 1'b1;
            end
            dist_we        = 1'b1;
            dist_waddr     = in_ch.payload.source_vertex;
            dist_wdata     = '0;
            scan_req.clear = 1'b1;
            state_d        = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_q < n_q) begin
          pv_d   = 1'b1;
          pidx_d = cnt_q[VtxW-1:0];
          cnt_d  = cnt_q + 1'b1;
        end
        if (pv_q) begin
          scan_req.sample = 1'b1;
          scan_req.cand   = tvalid_q[pidx_q] && !visited_q[pidx_q];
        end
        if (cnt_q == n_q && !pv_q) begin
          cnt_d = '0;
          if (scan_res.found) begin
            visited_d[scan_res.idx] = 1'b1;
            sel_d   = scan_res.idx;
            seld_d  = scan_res.cost;
            state_d = ST_RELAX;
          end else begin
            state_d = ST_OUT_RD;
          end
        end
      end
      ST_RELAX: begin
        if (cnt_q < n_q) begin
          pv_d   = 1'b1;
          pidx_d = cnt_q[VtxW-1:0];
          cnt_d  = cnt_q + 1'b1;
        end
        if (pv_q && edge_rdata[EdgeW-1] && !visited_q[pidx_q] &&
            (!tvalid_q[pidx_q] || dist_rdata > relax_nd)) begin
          dist_we          = 1'b1;
          tvalid_d[pidx_q] = 1'b1;
        end
        if (cnt_q == n_q && !pv_q) begin
          cnt_d          = '0;
          scan_req.clear = 1'b1;
          state_d        = ST_SCAN;
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        out_d.vertex_index = cnt_q[VtxW-1:0];
        out_d.reachable    = visited_q[cnt_q[VtxW-1:0]];
        out_d.path_length  = visited_q[cnt_q[VtxW-1:0]] ? dist_rdata : '0;
        out_d.last_result  = (cnt_q + 1'b1) == n_q;
        out_valid_d        = 1'b1;
        state_d            = ST_OUT_HOLD;
      end
      ST_OUT_HOLD: begin
        if (out_ch.ready) begin
          out_valid_d = 1'b0;
          if (out_q.last_result) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      vcount_q    <= CountW'(MaxVertices);
      n_q         <= CountW'(1);
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      visited_q   <= '0;
      tvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      vcount_q    <= vcount_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      visited_q   <= visited_d;
      tvalid_q    <= tvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    sel_q  <= sel_d;
    seld_q <= seld_d;
    out_q  <= out_d;
  end

  assign in_ch.ready    = (state_q == ST_IDLE);
  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_q;

  `DGSP_ASSERT(a_idle_no_pending, out_ch.valid |-> !in_ch.ready, "result pending while idle")
  `DGSP_ASSERT(a_last_is_final, (out_ch.valid && out_ch.payload.last_result) |-> ({1'b0, out_ch.payload.vertex_index} + 1'b1 == n_q), "last result on wrong vertex")
  `DGSP_ASSERT(a_no_relax_visited, (state_q == ST_RELAX && dist_we) |-> !visited_q[pidx_q], "relaxed a finalized vertex")
  `DGSP_ASSERT_ALWAYS(a_visited_valid, (visited_q & ~tvalid_q) == '0, "finalized vertex without distance")

endmodule
`default_nettype wire

@@ design/dgsp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module dgsp_ram #(
  parameter int Depth = 64,
  parameter int Width = 22
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ design/dgsp_scan.sv @@
// Running minimum over the candidate list, lowest index kept on ties.
`default_nettype none
module dgsp_scan (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dgsp_pkg::scan_req_t req_i,
  output      dgsp_pkg::scan_res_t res_o
);
  import dgsp_pkg::*;

  scan_res_t best_q, best_d;

  always_comb begin
    best_d = best_q;
    if (req_i.clear) begin
      best_d.found = 1'b0;
    end else if (req_i.sample && req_i.cand &&
                 (!best_q.found || req_i.cost < best_q.cost)) begin
      best_d.found = 1'b1;
      best_d.idx   = req_i.idx;
      best_d.cost  = req_i.cost;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q.found <= 1'b0;
      best_q.idx   <= '0;
      best_q.cost  <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign res_o = best_q;

endmodule
`default_nettype wire

@@ test/dense_graph_shortest_path_core_tb.sv @@
// Testbench for the dense-graph shortest-path core: directed, random and backpressure tests.
`timescale 1ns / 1ps
module dense_graph_shortest_path_core_tb;
  import dgsp_pkg::*;

  localparam int StallLimit = 60000;
  localparam int HoldCycles = 3000;
  localparam int PrintLimit = 40;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CountW-1:0] cfg_data_i;

  dgsp_in_if  in_ch ();
  dgsp_out_if out_ch ();

  dense_graph_shortest_path_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #10 clk_i = ~clk_i;

  bit                  edge_on [MaxVertices][MaxVertices];
  bit [WeightBits-1:0] edge_w  [MaxVertices][MaxVertices];
  logic [CountW-1:0]   vertex_count_q = CountW'(64);
  out_item_t           path_results_q[$];
  out_item_t           want_item;

  int  mismatch_count = 0;
  int  n_writes = 0;
  int  n_runs = 0;
  int  n_results = 0;
  int  stall_cycles = 0;
  bit  idle_in = 1'b1;
  bit  idle_out = 1'b1;
  logic hold_go = 1'b0;
  logic stall_hold = 1'b0;

  function automatic int unsigned active_vertices();
    int unsigned n;
    n = vertex_count_q;
    if (n == 0) n = 1;
    if (n > MaxVertices) n = MaxVertices;
    return n;
  endfunction

  function automatic void store_edge(input in_item_t it);
    edge_on[it.from_vertex][it.to_vertex] = it.edge_present;
    edge_w[it.from_vertex][it.to_vertex]  = it.edge_present ? it.edge_weight : '0;
  endfunction

  function automatic void compute_shortest_paths(input logic [VtxW-1:0] src);
    int unsigned     n;
    int unsigned     sel;
    int              i;
    bit              found;
    bit              seen [MaxVertices];
    bit              done [MaxVertices];
    int unsigned     best_cost [MaxVertices];
    longint unsigned cand;
    out_item_t       r;
    n = active_vertices();
    for (i = 0; i < MaxVertices; i++) begin
      seen[i] = 1'b0;
      done[i] = 1'b0;
      best_cost[i] = 0;
    end
    if (src < n) seen[src] = 1'b1;
    while (1) begin
      found = 1'b0;
      sel = 0;
      for (i = 0; i < n; i++) begin
        if (seen[i] && !done[i] && (!found || best_cost[sel] > best_cost[i])) begin
          sel = i;
          found = 1'b1;
        end
      end
      if (!found) break;
      done[sel] = 1'b1;
      for (i = 0; i < n; i++) begin
        if (edge_on[sel][i] && !done[i]) begin
          cand = longint'(best_cost[sel]) + edge_w[sel][i];
          if (cand > DistMax) cand = DistMax;
          if (!seen[i] || best_cost[i] > cand) begin
            best_cost[i] = int'(cand);
            seen[i] = 1'b1;
          end
        end
      end
    end
    for (i = 0; i < n; i++) begin
      r.vertex_index = i[VtxW-1:0];
      r.reachable    = done[i];
      r.path_length  = done[i] ? best_cost[i][DistW-1:0] : '0;
      r.last_result  = (i == n - 1);
      path_results_q.push_back(r);
    end
  endfunction

  function automatic in_item_t edge_item(input int from, input int to, input bit present,
                                         input int weight);
    in_item_t it;
    it.cmd           = CmdWrite;
    it.from_vertex   = from[VtxW-1:0];
    it.to_vertex     = to[VtxW-1:0];
    it.edge_present  = present;
    it.edge_weight   = weight[WeightBits-1:0];
    it.source_vertex = VtxW'($urandom_range(0, MaxVertices - 1));
    return it;
  endfunction

  function automatic in_item_t run_item(input int src);
    in_item_t it;
    it.cmd           = CmdRun;
    it.from_vertex   = VtxW'($urandom_range(0, MaxVertices - 1));
    it.to_vertex     = VtxW'($urandom_range(0, MaxVertices - 1));
    it.edge_present  = 1'($urandom_range(0, 1));
    it.edge_weight   = WeightBits'($urandom_range(0, 65535));
    it.source_vertex = src[VtxW-1:0];
    return it;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < PrintLimit)
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Hold valid until the transaction is taken, then update the model.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = idle_in ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (it.cmd == CmdWrite) begin
      store_edge(it);
      n_writes++;
    end else begin
      compute_shortest_paths(it.source_vertex);
      n_runs++;
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (path_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(input int value);
    wait_idle();
    cfg_we_i       <= 1'b1;
    cfg_data_i     <= value[CountW-1:0];
    vertex_count_q  = value[CountW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed_paths();
    send_item(edge_item(0, 1, 1'b1, 3));
    send_item(edge_item(0, 2, 1'b1, 3));
    send_item(edge_item(1, 63, 1'b1, 65535));
    send_item(edge_item(2, 63, 1'b1, 10));
    send_item(edge_item(63, 0, 1'b1, 0));
    send_item(edge_item(2, 2, 1'b1, 7));
    send_item(edge_item(0, 3, 1'b1, 100));
    send_item(edge_item(0, 3, 1'b0, 65535));
    send_item(edge_item(3, 4, 1'b1, 1));
    send_item(run_item(0));
    send_item(run_item(63));
    set_vertex_count(5);
    send_item(run_item(0));
    send_item(run_item(7));
    set_vertex_count(0);
    send_item(run_item(0));
    send_item(run_item(1));
    set_vertex_count(127);
    send_item(run_item(2));
    set_vertex_count(1);
    send_item(run_item(63));
  endtask

  task automatic test_random_graphs();
    int counts[6] = '{4, 16, 2, 64, 9, 12};
    int n;
    int sent;
    int k;
    int w;
    for (int p = 0; p < 6; p++) begin
      n = counts[p];
      set_vertex_count(n);
      idle_in  = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 18) begin
        if ($urandom_range(0, 9) < 8) begin
          k = $urandom_range(1, 5);
          repeat (k) begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
            send_item(edge_item($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                ($urandom_range(0, 5) != 0), w));
          end
          send_item(run_item($urandom_range(0, n - 1)));
          sent += k + 1;
        end else begin
          case ($urandom_range(0, 2))
            0: send_item(edge_item($urandom_range(0, 63), $urandom_range(0, 63),
                                   1'($urandom_range(0, 1)), $urandom_range(0, 65535)));
            1: send_item(edge_item($urandom_range(0, n - 1), $urandom_range(0, n - 1), 1'b0,
                                   $urandom_range(0, 65535)));
            default: send_item(run_item($urandom_range(0, 63)));
          endcase
          sent++;
        end
      end
    end
  endtask

  task automatic test_output_backpressure();
    set_vertex_count(20);
    idle_in  = 1'b0;
    idle_out = 1'b0;
    hold_go <= 1'b1;
    repeat (8) send_item(run_item($urandom_range(0, 19)));
    idle_in  = 1'b1;
    idle_out = 1'b1;
  endtask

  initial begin
    wait (hold_go === 1'b1);
    @(posedge clk_i);
    stall_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    stall_hold <= 1'b0;
  end

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = idle_out ? $urandom_range(0, 4) : 0;
      if (gap > 0 || stall_hold) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (stall_hold) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid && !stall_hold) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (path_results_q.size() == 0) begin
        report_mismatch("unexpected result at vertex", out_ch.payload.vertex_index, 0);
      end else begin
        want_item = path_results_q.pop_front();
        n_results++;
        if (out_ch.payload.vertex_index !== want_item.vertex_index)
          report_mismatch("vertex_index", out_ch.payload.vertex_index, want_item.vertex_index);
        if (out_ch.payload.reachable !== want_item.reachable)
          report_mismatch("reachable", out_ch.payload.reachable, want_item.reachable);
        if (out_ch.payload.path_length !== want_item.path_length)
          report_mismatch("path_length", out_ch.payload.path_length, want_item.path_length);
        if (out_ch.payload.last_result !== want_item.last_result)
          report_mismatch("last_result", out_ch.payload.last_result, want_item.last_result);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no transaction for %0d cycles", StallLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_data_i    <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_paths();
    test_random_graphs();
    test_output_backpressure();
    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("covered %0d edge writes and %0d runs over vertex counts 0 to 127",
             n_writes, n_runs);
    $display("checked %0d vertex results, %0d mismatches", n_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
